/* hdl/pmst_pkg.sv */
// Shared constants and types for the Prim minimum spanning tree unit.
// No dependencies; the two interfaces and the top unit import it.
package pmst_pkg;

  localparam int VERTICES    = 16;
  localparam int VIDX_BITS   = $clog2(VERTICES);
  localparam int WEIGHT_BITS = 16;
  localparam int KEY_BITS    = WEIGHT_BITS + 1;
  localparam int COST_BITS   = 20;
  localparam int ADDR_BITS   = 2 * VIDX_BITS;
  localparam int MAT_DEPTH   = VERTICES * VERTICES;
  localparam int VCOUNT_BITS = 5;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  typedef logic [VIDX_BITS-1:0]     vidx_t;
  typedef logic [WEIGHT_BITS-1:0]   weight_t;
  typedef logic [KEY_BITS-1:0]      key_t;
  typedef logic [COST_BITS-1:0]     cost_t;
  typedef logic [ADDR_BITS-1:0]     mat_addr_t;
  typedef logic [VCOUNT_BITS-1:0]   vcount_t;
  typedef logic [APB_ADDR_BITS-1:0] apb_addr_t;
  typedef logic [APB_DATA_BITS-1:0] apb_data_t;

  // Key value that stands for "no edge to the tree yet"
  localparam key_t KEY_INF = key_t'(1) << WEIGHT_BITS;

  // Register map: index of each register, byte address is 4 * index
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam vcount_t VCOUNT_RESET  = vcount_t'(16);
  localparam vcount_t VCOUNT_MIN    = vcount_t'(2);
  localparam vcount_t VCOUNT_MAX    = vcount_t'(VERTICES);

endpackage

/* hdl/pmst_load_if.sv */
// Input channel of the unit: one adjacency matrix entry per item.
// Depends on pmst_pkg.
interface pmst_load_if;
  import pmst_pkg::*;

  logic    valid;
  logic    ready;
  vidx_t   row_vertex;
  vidx_t   col_vertex;
  weight_t edge_cost;
  logic    load_done;

  modport source (output valid, row_vertex, col_vertex, edge_cost, load_done, input ready);
  modport sink   (input valid, row_vertex, col_vertex, edge_cost, load_done, output ready);
endinterface

/* hdl/pmst_tree_if.sv */
// Output channel of the unit: one spanning tree edge per item.
// Depends on pmst_pkg.
interface pmst_tree_if;
  import pmst_pkg::*;

  logic    valid;
  logic    ready;
  vidx_t   parent_vertex;
  vidx_t   child_vertex;
  weight_t tree_edge_cost;
  logic    unreachable;
  cost_t   cost_so_far;
  logic    final_edge;

  modport source (output valid, parent_vertex, child_vertex, tree_edge_cost, unreachable,
                  cost_so_far, final_edge, input ready);
  modport sink   (input valid, parent_vertex, child_vertex, tree_edge_cost, unreachable,
                  cost_so_far, final_edge, output ready);
endinterface

/* hdl/pmst_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pmst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/prim_minimum_spanning_tree_unit.sv */
// Prim minimum spanning tree over a 16 x 16 weighted adjacency matrix.
// A matrix entry item is taken only while idle. An entry with load_done starts a run of
// n - 1 passes (n = active vertex count); each pass reads one matrix row through the
// single RAM read port and one shared relax/compare unit, then issues the tree edge;
// a tree edge may wait for tree.ready, and no input is taken meanwhile.
// Reset (rst, synchronous) clears all 256 matrix RAM entries in a pass; no item taken then.
module prim_minimum_spanning_tree_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  pmst_pkg::apb_addr_t paddr,
  input  pmst_pkg::apb_data_t pwdata,
  output pmst_pkg::apb_data_t prdata,
  output logic                pready,
  pmst_load_if.sink           load,
  pmst_tree_if.source         tree
);
  import pmst_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PASS,
    ST_EMIT
  } state_t;

  state_t    state;
  mat_addr_t clr_addr;
  vcount_t   vertex_count;
  vidx_t     last_v;      // active vertex count minus one
  vidx_t     pick;        // vertex whose row is being scanned
  vidx_t     step;        // number of the next tree edge
  cost_t     run_cost;

  // Per-vertex state
  key_t   best_key     [VERTICES];
  vidx_t  parent_store [VERTICES];
  logic [VERTICES-1:0] in_tree;

  // Row scan
  vidx_t rd_v;
  logic  issue;
  vidx_t p_v;
  logic  p_vld;

  // Minimum tracking over one pass
  key_t  low;
  vidx_t low_idx;
  vidx_t low_par;
  logic  found;
  vidx_t free_idx;
  logic  have_free;

  // Output register
  logic    out_valid;
  vidx_t   out_parent;
  vidx_t   out_child;
  weight_t out_cost;
  logic    out_unreach;
  cost_t   out_total;
  logic    out_final;

  // Matrix RAM ports
  logic      ram_we;
  mat_addr_t ram_waddr;
  weight_t   ram_wdata;
  mat_addr_t ram_raddr;
  weight_t   ram_rdata;

  pmst_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAT_DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic    load_take;
  logic    cfg_write;
  logic    emit_go;
  vcount_t n_clamped;

  assign load.ready = (state == ST_IDLE);
  assign load_take  = load.valid && (state == ST_IDLE);
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite;
  assign emit_go    = (state == ST_EMIT) && (!out_valid || tree.ready);
  assign prdata     = (paddr[2] == REG_VERTEX_COUNT) ?
                      apb_data_t'(vertex_count) : '0;

  // Clamp the vertex count to the supported range
  always_comb begin
    if (vertex_count < VCOUNT_MIN) begin
      n_clamped = VCOUNT_MIN;
    end else if (vertex_count > VCOUNT_MAX) begin
      n_clamped = VCOUNT_MAX;
    end else begin
      n_clamped = vertex_count;
    end
  end

  // Matrix write: clearing pass or loaded entry; read: row of the current pick
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = load_take;
      ram_waddr = {load.row_vertex, load.col_vertex};
      ram_wdata = load.edge_cost;
    end
    ram_raddr = {pick, rd_v};
  end

  // Shared relax and compare unit: one vertex per cycle
  key_t  cur_key;
  logic  cur_in;
  logic  relax;
  key_t  new_key;
  vidx_t new_par;
  logic  better;

  always_comb begin
    cur_key = best_key[p_v];
    cur_in  = in_tree[p_v];
    relax   = (ram_rdata != '0) && !cur_in && (key_t'(ram_rdata) < cur_key);
    new_key = relax ? key_t'(ram_rdata) : cur_key;
    new_par = relax ? pick : parent_store[p_v];
    better  = p_vld && !cur_in && (new_key < low);
  end

  // Choice of the next vertex at the end of a pass
  vidx_t   sel_pick;
  vidx_t   sel_par;
  weight_t sel_w;
  logic    sel_final;

  always_comb begin
    sel_pick  = found ? low_idx : free_idx;
    sel_par   = found ? low_par : '0;
    sel_w     = found ? low[WEIGHT_BITS-1:0] : '0;
    sel_final = (step == last_v);
  end

  // Sequencer, per-vertex state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      vertex_count <= VCOUNT_RESET;
      out_valid    <= 1'b0;
      issue        <= 1'b0;
      p_vld        <= 1'b0;
      in_tree      <= '0;
    end else begin
      if (cfg_write && (paddr[2] == REG_VERTEX_COUNT)) begin
        vertex_count <= pwdata[VCOUNT_BITS-1:0];
      end
      if (tree.ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      p_vld <= issue;
      p_v   <= rd_v;

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == mat_addr_t'(MAT_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          // Store the entry; on the last one set up a run rooted at vertex 0
          if (load_take && load.load_done) begin
            last_v     <= vidx_t'(n_clamped - 1'b1);
            for (int i = 0; i < VERTICES; i++) begin
              best_key[i]     <= KEY_INF;
              parent_store[i] <= '0;
            end
            in_tree    <= VERTICES'(1);
            pick       <= '0;
            step       <= vidx_t'(1);
            run_cost   <= '0;
            rd_v       <= '0;
            issue      <= 1'b1;
            low        <= KEY_INF;
            found      <= 1'b0;
            have_free  <= 1'b0;
            state      <= ST_PASS;
          end
        end

        ST_PASS: begin
          // Issue row reads
          if (issue) begin
            rd_v <= rd_v + 1'b1;
            if (rd_v == last_v) begin
              issue <= 1'b0;
            end
          end
          // Relax one vertex and track the minimum key
          if (p_vld) begin
            best_key[p_v]     <= new_key;
            parent_store[p_v] <= new_par;
            if (better) begin
              low     <= new_key;
              low_idx <= p_v;
              low_par <= new_par;
              found   <= 1'b1;
            end
            if (!cur_in && !have_free) begin
              free_idx  <= p_v;
              have_free <= 1'b1;
            end
            if (p_v == last_v) begin
              state <= ST_EMIT;
            end
          end
        end

        ST_EMIT: begin
          // Hand the tree edge to the output register once it is free
          if (emit_go) begin
            out_valid   <= 1'b1;
            out_parent  <= sel_par;
            out_child   <= sel_pick;
            out_cost    <= sel_w;
            out_unreach <= !found;
            out_total   <= run_cost + cost_t'(sel_w);
            out_final   <= sel_final;
            run_cost    <= run_cost + cost_t'(sel_w);
            in_tree[sel_pick] <= 1'b1;
            pick        <= sel_pick;
            step        <= step + 1'b1;
            if (sel_final) begin
              state <= ST_IDLE;
            end else begin
              rd_v      <= '0;
              issue     <= 1'b1;
              low       <= KEY_INF;
              found     <= 1'b0;
              have_free <= 1'b0;
              state     <= ST_PASS;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign tree.valid          = out_valid;
  assign tree.parent_vertex  = out_parent;
  assign tree.child_vertex   = out_child;
  assign tree.tree_edge_cost = out_cost;
  assign tree.unreachable    = out_unreach;
  assign tree.cost_so_far    = out_total;
  assign tree.final_edge     = out_final;

endmodule
